### rtl/core/rpa_pkg.sv
`default_nettype none
package rpa_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Angle register: degrees, 8 fraction bits
  localparam int unsigned ANG_W = 18;
  // Shift from 8 to 24 angle fraction bits
  localparam int unsigned ANG_FRAC_SHIFT = 16;

  localparam logic signed [ANG_W:0] ANG_FULL_TURN    = 19'sd92160;
  localparam logic signed [ANG_W:0] ANG_HALF_TURN    = 19'sd46080;
  localparam logic signed [ANG_W:0] ANG_QUARTER_TURN = 19'sd23040;

  // CORDIC vector in Q2.30 with one guard bit, angle in Q8.24 degrees
  localparam int unsigned CX_W    = 33;
  localparam int unsigned CX_FRAC = 30;
  localparam int unsigned CZ_W    = 32;

  // Widest product sum the sine and cosine precision is fitted to
  localparam int unsigned PROD_BUDGET = 62;

  localparam logic signed [CX_W-1:0] GAIN_Q30 = 33'sd652032875;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } rpa_axis_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AXIS  = 4'd0,
    CFG_ANGLE = 4'd1
  } rpa_cfg_idx_e;

  typedef struct packed {
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [CZ_W-1:0] z;
  } rpa_rot_t;

  typedef struct packed {
    rpa_axis_e axis;
    logic      flip;
  } rpa_cfg_t;

  // Fraction bits kept for sine and cosine
  function automatic int unsigned trig_frac(input int unsigned coord_w);
    return (PROD_BUDGET - coord_w > CX_FRAC) ? CX_FRAC : PROD_BUDGET - coord_w;
  endfunction

  // atan(2^-i) in degrees, 24 fraction bits
  function automatic logic signed [CZ_W-1:0] atan_deg_q24(input int unsigned idx);
    logic signed [CZ_W-1:0] r;
    unique case (idx)
      0:       r = 32'sd754974720;
      1:       r = 32'sd445687602;
      2:       r = 32'sd235489088;
      3:       r = 32'sd119537938;
      4:       r = 32'sd60000934;
      5:       r = 32'sd30029717;
      6:       r = 32'sd15018523;
      7:       r = 32'sd7509720;
      8:       r = 32'sd3754917;
      9:       r = 32'sd1877466;
      10:      r = 32'sd938734;
      11:      r = 32'sd469367;
      12:      r = 32'sd234684;
      13:      r = 32'sd117342;
      14:      r = 32'sd58671;
      15:      r = 32'sd29335;
      16:      r = 32'sd14668;
      17:      r = 32'sd7334;
      18:      r = 32'sd3667;
      19:      r = 32'sd1833;
      20:      r = 32'sd917;
      21:      r = 32'sd458;
      22:      r = 32'sd229;
      23:      r = 32'sd115;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/core/rpa_point_if.sv
`default_nettype none
interface rpa_point_if #(
  parameter int unsigned COORD_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] coord_x;
  logic signed [COORD_WIDTH-1:0] coord_y;
  logic signed [COORD_WIDTH-1:0] coord_z;
  logic                          last_point;

  modport source (output valid, coord_x, coord_y, coord_z, last_point, input ready);
  modport sink (input valid, coord_x, coord_y, coord_z, last_point, output ready);
endinterface
`default_nettype wire

### rtl/core/rpa_result_if.sv
`default_nettype none
interface rpa_result_if #(
  parameter int unsigned COORD_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] rot_x;
  logic signed [COORD_WIDTH-1:0] rot_y;
  logic signed [COORD_WIDTH-1:0] rot_z;
  logic                          last_out;
  logic                          saturated;

  modport source (output valid, rot_x, rot_y, rot_z, last_out, saturated, input ready);
  modport sink (input valid, rot_x, rot_y, rot_z, last_out, saturated, output ready);
endinterface
`default_nettype wire

### rtl/core/rpa_cfg_if.sv
`default_nettype none
interface rpa_cfg_if
  import rpa_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/core/rpa_cordic_stage.sv
`default_nettype none
module rpa_cordic_stage
  import rpa_pkg::*;
#(
  parameter int unsigned STAGE = 0,
  parameter int unsigned PAY_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  rpa_rot_t         rot_i,
  input  logic [PAY_W-1:0] pay_i,
  output logic             valid_o,
  input  logic             ready_i,
  output rpa_rot_t         rot_o,
  output logic [PAY_W-1:0] pay_o
);

  localparam logic signed [CZ_W-1:0] STEP = atan_deg_q24(STAGE);

  logic                   v_q;
  rpa_rot_t               rot_d, rot_q;
  logic [PAY_W-1:0]       pay_q;
  logic signed [CX_W-1:0] x_sh, y_sh;

  // One micro-rotation: steer toward zero residual angle
  always_comb begin
    x_sh = $signed(rot_i.x) >>> STAGE;
    y_sh = $signed(rot_i.y) >>> STAGE;
    if (rot_i.z[CZ_W-1]) begin
      rot_d.x = rot_i.x + y_sh;
      rot_d.y = rot_i.y - x_sh;
      rot_d.z = rot_i.z + STEP;
    end else begin
      rot_d.x = rot_i.x - y_sh;
      rot_d.y = rot_i.y + x_sh;
      rot_d.z = rot_i.z - STEP;
    end
  end

  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rot_q <= rot_d;
      pay_q <= pay_i;
    end
  end

  assign valid_o = v_q;
  assign rot_o   = rot_q;
  assign pay_o   = pay_q;

endmodule
`default_nettype wire

### rtl/core/rpa_mix.sv
`default_nettype none
module rpa_mix
  import rpa_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rpa_cfg_t                        cfg_i,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  rpa_rot_t                        rot_i,
  input  logic [3*COORD_WIDTH:0]          pay_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output logic signed [COORD_WIDTH-1:0]   rot_x_o,
  output logic signed [COORD_WIDTH-1:0]   rot_y_o,
  output logic signed [COORD_WIDTH-1:0]   rot_z_o,
  output logic                            last_o,
  output logic                            sat_o
);

  localparam int unsigned W     = COORD_WIDTH;
  localparam int unsigned PAY_W = 3 * W + 1;
  localparam int unsigned T     = trig_frac(W);
  localparam int unsigned TW    = T + 2;
  localparam int unsigned SH    = CX_FRAC - T;
  localparam int unsigned PW    = W + TW;
  localparam int unsigned SW    = PW + 1;
  localparam int unsigned RW    = SW - T;

  localparam logic signed [CX_W-1:0] RND_A    = CX_W'((64'd1 << SH) >> 1);
  localparam logic signed [SW-1:0]   RND_C    = SW'(64'd1 << (T - 1));
  localparam logic signed [TW-1:0]   TRIG_LIM = TW'((64'd1 << T) + (64'd1 << (T - 4)));
  localparam logic [W-1:0]           COORD_MAX = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0]           COORD_MIN = ~COORD_MAX;

  logic a_rdy, b_rdy, c_rdy, d_rdy;

  // ---------------- Stage A: sign fold and rounding of cos/sin
  logic                   a_v_q;
  logic signed [TW-1:0]   a_cs_q, a_sn_q;
  logic [PAY_W-1:0]       a_pay_q;
  logic signed [CX_W-1:0] xf, yf, cs_sum, sn_sum, cs_shr, sn_shr;
  logic signed [TW-1:0]   cs_d, sn_d;

  always_comb begin
    xf     = cfg_i.flip ? -$signed(rot_i.x) : $signed(rot_i.x);
    yf     = cfg_i.flip ? -$signed(rot_i.y) : $signed(rot_i.y);
    cs_sum = xf + RND_A;
    sn_sum = yf + RND_A;
    cs_shr = cs_sum >>> SH;
    sn_shr = sn_sum >>> SH;
    cs_d   = cs_shr[TW-1:0];
    sn_d   = sn_shr[TW-1:0];
  end

  assign a_rdy   = !a_v_q || b_rdy;
  assign ready_o = a_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (a_rdy) begin
      a_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && valid_i) begin
      a_cs_q  <= cs_d;
      a_sn_q  <= sn_d;
      a_pay_q <= pay_i;
    end
  end

  // ---------------- Stage B: pick the rotated pair, four products
  logic                 b_v_q;
  logic signed [PW-1:0] b_ucs_q, b_vsn_q, b_vcs_q, b_usn_q;
  logic [PAY_W-1:0]     b_pay_q;
  logic signed [W-1:0]  a_x, a_y, a_z, u, v;
  logic signed [PW-1:0] ucs_d, vsn_d, vcs_d, usn_d;

  always_comb begin
    a_x = a_pay_q[3*W-1:2*W];
    a_y = a_pay_q[2*W-1:W];
    a_z = a_pay_q[W-1:0];
    // first = u*cos - v*sin, second = v*cos + u*sin
    unique case (cfg_i.axis)
      AXIS_X: begin
        u = a_y;
        v = a_z;
      end
      AXIS_Y: begin
        u = a_z;
        v = a_x;
      end
      AXIS_Z: begin
        u = a_x;
        v = a_y;
      end
      default: begin
        u = a_x;
        v = a_y;
      end
    endcase
    ucs_d = PW'(u) * PW'(a_cs_q);
    vsn_d = PW'(v) * PW'(a_sn_q);
    vcs_d = PW'(v) * PW'(a_cs_q);
    usn_d = PW'(u) * PW'(a_sn_q);
  end

  assign b_rdy = !b_v_q || c_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (b_rdy) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_rdy && a_v_q) begin
      b_ucs_q <= ucs_d;
      b_vsn_q <= vsn_d;
      b_vcs_q <= vcs_d;
      b_usn_q <= usn_d;
      b_pay_q <= a_pay_q;
    end
  end

  // ---------------- Stage C: sum, round half up, drop fraction
  logic                 c_v_q;
  logic signed [RW-1:0] c_r1_q, c_r2_q;
  logic [PAY_W-1:0]     c_pay_q;
  logic signed [SW-1:0] s1, s2, s1_shr, s2_shr;
  logic signed [RW-1:0] r1_d, r2_d;

  always_comb begin
    s1     = SW'(b_ucs_q) - SW'(b_vsn_q) + RND_C;
    s2     = SW'(b_vcs_q) + SW'(b_usn_q) + RND_C;
    s1_shr = s1 >>> T;
    s2_shr = s2 >>> T;
    r1_d   = s1_shr[RW-1:0];
    r2_d   = s2_shr[RW-1:0];
  end

  assign c_rdy = !c_v_q || d_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (c_rdy) begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_rdy && b_v_q) begin
      c_r1_q  <= r1_d;
      c_r2_q  <= r2_d;
      c_pay_q <= b_pay_q;
    end
  end

  // ---------------- Stage D: clip and place into the output register
  logic                d_v_q;
  logic signed [W-1:0] d_x_q, d_y_q, d_z_q;
  logic                d_last_q, d_sat_q;
  logic [RW-W:0]       top1, top2;
  logic                clip1, clip2;
  logic signed [W-1:0] q1, q2, c_x, c_y, c_z;
  logic signed [W-1:0] x_d, y_d, z_d;
  logic                sat_d;

  always_comb begin
    c_x   = c_pay_q[3*W-1:2*W];
    c_y   = c_pay_q[2*W-1:W];
    c_z   = c_pay_q[W-1:0];
    top1  = c_r1_q[RW-1:W-1];
    top2  = c_r2_q[RW-1:W-1];
    clip1 = !((&top1) || !(|top1));
    clip2 = !((&top2) || !(|top2));
    q1    = clip1 ? {c_r1_q[RW-1], {(W - 1){~c_r1_q[RW-1]}}} : c_r1_q[W-1:0];
    q2    = clip2 ? {c_r2_q[RW-1], {(W - 1){~c_r2_q[RW-1]}}} : c_r2_q[W-1:0];
    unique case (cfg_i.axis)
      AXIS_X: begin
        x_d   = c_x;
        y_d   = q1;
        z_d   = q2;
        sat_d = clip1 || clip2;
      end
      AXIS_Y: begin
        x_d   = q2;
        y_d   = c_y;
        z_d   = q1;
        sat_d = clip1 || clip2;
      end
      AXIS_Z: begin
        x_d   = q1;
        y_d   = q2;
        z_d   = c_z;
        sat_d = clip1 || clip2;
      end
      default: begin
        x_d   = c_x;
        y_d   = c_y;
        z_d   = c_z;
        sat_d = 1'b0;
      end
    endcase
  end

  assign d_rdy = !d_v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
    end else if (d_rdy) begin
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_rdy && c_v_q) begin
      d_x_q    <= x_d;
      d_y_q    <= y_d;
      d_z_q    <= z_d;
      d_last_q <= c_pay_q[PAY_W-1];
      d_sat_q  <= sat_d;
    end
  end

  assign valid_o = d_v_q;
  assign rot_x_o = d_x_q;
  assign rot_y_o = d_y_q;
  assign rot_z_o = d_z_q;
  assign last_o  = d_last_q;
  assign sat_o   = d_sat_q;

  // ---------------- Checks
  logic rail_x, rail_y, rail_z;

  assign rail_x = (d_x_q == COORD_MAX) || (d_x_q == COORD_MIN);
  assign rail_y = (d_y_q == COORD_MAX) || (d_y_q == COORD_MIN);
  assign rail_z = (d_z_q == COORD_MAX) || (d_z_q == COORD_MIN);

  a_sat_on_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_v_q && d_sat_q) |-> (rail_x || rail_y || rail_z))
    else $error("saturated flag without a clipped coordinate");

  a_no_sat_passthrough: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_v_q && cfg_i.axis == AXIS_NONE) |-> !d_sat_q)
    else $error("saturation reported on pass-through axis");

  a_trig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_v_q |-> (a_cs_q <= TRIG_LIM && a_cs_q >= -TRIG_LIM &&
               a_sn_q <= TRIG_LIM && a_sn_q >= -TRIG_LIM))
    else $error("sine or cosine out of unit range");

  a_trig_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_v_q && !b_rdy) |=> (a_v_q && $stable(a_cs_q) && $stable(a_sn_q)))
    else $error("stalled trig stage lost its item");

endmodule
`default_nettype wire

### rtl/core/rotate_points_about_axis.sv
`default_nettype none
// Channel    Dir  Handshake      Payload
// point_i    in   valid/ready    coord_x, coord_y, coord_z, last_point
// result_o   out  valid/ready    rot_x, rot_y, rot_z, last_out, saturated
// cfg_i      in   valid/ready    index (0 axis, 1 angle), data
//
// One item per cycle sustained while result_o.ready stays high; each CORDIC stage
// registers one micro-rotation, then registered trig rounding, multiply, sum and clip.
// Reset clears every stage valid and sets axis X, angle 0.
// Each stage holds its item while the stage after it is full and stalled; empty stages
// collapse, so input ready follows result_o.ready combinationally.
// cfg_i is always ready; angle folding happens at the write.
module rotate_points_about_axis
  import rpa_pkg::*;
#(
  parameter int unsigned COORD_WIDTH   = 32,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rpa_point_if.sink    point_i,
  rpa_result_if.source result_o,
  rpa_cfg_if.sink      cfg_i
);

  localparam int unsigned PAY_W = 3 * COORD_WIDTH + 1;

  // ---------------- Configuration registers
  // The angle is stored already reduced to [-90, 90] degrees in CORDIC units,
  // with a flag that negates both sine and cosine for the folded half turn.
  rpa_axis_e              axis_q;
  logic signed [CZ_W-1:0] z0_q, z0_d;
  logic                   flip_q, flip_d;
  logic signed [ANG_W:0]  ang_raw, ang_red, ang_fold;
  logic                   cfg_wr;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;

  always_comb begin
    ang_raw = (ANG_W + 1)'($signed(cfg_i.data[ANG_W-1:0]));
    // Wrap into [-180, 180); one step covers the whole register range
    priority if (ang_raw >= ANG_HALF_TURN) begin
      ang_red = ang_raw - ANG_FULL_TURN;
    end else if (ang_raw < -ANG_HALF_TURN) begin
      ang_red = ang_raw + ANG_FULL_TURN;
    end else begin
      ang_red = ang_raw;
    end
    // Fold the outer half turn onto [-90, 90] and remember the sign flip
    priority if (ang_red > ANG_QUARTER_TURN) begin
      ang_fold = ang_red - ANG_HALF_TURN;
      flip_d   = 1'b1;
    end else if (ang_red < -ANG_QUARTER_TURN) begin
      ang_fold = ang_red + ANG_HALF_TURN;
      flip_d   = 1'b1;
    end else begin
      ang_fold = ang_red;
      flip_d   = 1'b0;
    end
    z0_d = {ang_fold[CZ_W-ANG_FRAC_SHIFT-1:0], {ANG_FRAC_SHIFT{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= AXIS_X;
      z0_q   <= '0;
      flip_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (rpa_cfg_idx_e'(cfg_i.index))
        CFG_AXIS: begin
          axis_q <= rpa_axis_e'(cfg_i.data[$bits(rpa_axis_e)-1:0]);
        end
        CFG_ANGLE: begin
          z0_q   <= z0_d;
          flip_q <= flip_d;
        end
        default: begin
          // unknown register: drop the write
        end
      endcase
    end
  end

  // ---------------- CORDIC pipeline
  // Every item carries its own CORDIC vector; the point rides along as payload.
  rpa_rot_t             rot [CORDIC_STAGES+1];
  logic [PAY_W-1:0]     pay [CORDIC_STAGES+1];
  logic [CORDIC_STAGES:0] vld, rdy;

  assign rot[0]        = '{x: GAIN_Q30, y: '0, z: z0_q};
  assign pay[0]        = {point_i.last_point, point_i.coord_x, point_i.coord_y,
                          point_i.coord_z};
  assign vld[0]        = point_i.valid;
  assign point_i.ready = rdy[0];

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
    rpa_cordic_stage #(
      .STAGE (s),
      .PAY_W (PAY_W)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[s]),
      .ready_o (rdy[s]),
      .rot_i   (rot[s]),
      .pay_i   (pay[s]),
      .valid_o (vld[s+1]),
      .ready_i (rdy[s+1]),
      .rot_o   (rot[s+1]),
      .pay_o   (pay[s+1])
    );
  end

  // ---------------- Rotation of the point and output register
  // The user must change config only while the block is empty; no check here, later stages read it live.
  rpa_cfg_t mix_cfg;

  assign mix_cfg = '{axis: axis_q, flip: flip_q};

  rpa_mix #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (mix_cfg),
    .valid_i (vld[CORDIC_STAGES]),
    .ready_o (rdy[CORDIC_STAGES]),
    .rot_i   (rot[CORDIC_STAGES]),
    .pay_i   (pay[CORDIC_STAGES]),
    .valid_o (result_o.valid),
    .ready_i (result_o.ready),
    .rot_x_o (result_o.rot_x),
    .rot_y_o (result_o.rot_y),
    .rot_z_o (result_o.rot_z),
    .last_o  (result_o.last_out),
    .sat_o   (result_o.saturated)
  );

endmodule
`default_nettype wire

### sim/rotate_points_about_axis_tb.sv
`timescale 1ns / 1ps
module rotate_points_about_axis_tb;
  import rpa_pkg::*;

  localparam int unsigned COORD_W        = 32;
  localparam int unsigned STAGES         = 16;
  localparam int unsigned LATENCY        = STAGES + 4;
  localparam int unsigned TRIG_FRAC      = (PROD_BUDGET - COORD_W > CX_FRAC) ?
                                           CX_FRAC : PROD_BUDGET - COORD_W;
  localparam int unsigned DIR_ROWS       = 20;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned PHASE_ITEMS    = 50;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 10;

  // Angles are degrees with 8 fraction bits; CORDIC angles carry 24
  localparam longint DEG     = 256;
  localparam longint QUARTER = 90 * DEG;
  localparam longint HALF    = 180 * DEG;
  localparam longint FULL    = 360 * DEG;

  // atan(2^-i) in degrees, 24 fraction bits
  localparam longint ARCTAN_STEP [24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t CMAX = 32'sh7fff_ffff;
  localparam coord_t CMIN = 32'sh8000_0000;

  typedef struct packed {
    coord_t coord_x;
    coord_t coord_y;
    coord_t coord_z;
    logic   last_point;
  } point_t;

  typedef struct packed {
    coord_t rot_x;
    coord_t rot_y;
    coord_t rot_z;
    logic   last_out;
    logic   saturated;
  } rotated_t;

  // One directed item with the setting it runs under; known marks rows whose
  // result is written down by hand instead of coming from the predictor
  typedef struct packed {
    rpa_axis_e               axis;
    logic signed [ANG_W-1:0] angle;
    point_t                  pt;
    logic                    known;
    rotated_t                known_res;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  rpa_point_if #(.COORD_WIDTH(COORD_W))  point_bus ();
  rpa_result_if #(.COORD_WIDTH(COORD_W)) result_bus ();
  rpa_cfg_if                             cfg_bus ();

  rotate_points_about_axis #(
    .COORD_WIDTH  (COORD_W),
    .CORDIC_STAGES(STAGES)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .point_i (point_bus),
    .result_o(result_bus),
    .cfg_i   (cfg_bus)
  );

  // Predictor copy of the two registers, updated on accepted writes
  rpa_axis_e               model_axis;
  logic signed [ANG_W-1:0] model_angle;

  rotated_t pending_rotations [$];

  // Hand-written expectation that rides along with the item being offered
  logic     point_known;
  rotated_t point_known_res;

  // Knobs shared by the sender and the receiver
  logic gaps_on;
  logic hold_req;

  int unsigned points_sent;
  int unsigned results_checked;
  int unsigned sat_seen;
  int unsigned cfg_writes;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  dir_row_t dir_rows [DIR_ROWS];

  wire point_fire  = point_bus.valid && point_bus.ready;
  wire result_fire = result_bus.valid && result_bus.ready;
  wire cfg_fire    = cfg_bus.valid && cfg_bus.ready;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic longint round_half_up(input longint v, input int unsigned s);
    if (s == 0) return v;
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // Gain-compensated CORDIC in degrees; fold the angle into [-90, 90] first
  // and flip both outputs when half a turn was taken off
  function automatic void cordic_sin_cos(input logic signed [ANG_W-1:0] angle,
                                         output longint cs, output longint sn);
    longint ang;
    longint x;
    longint y;
    longint z;
    longint nx;
    logic   flip;
    ang  = angle;
    flip = 1'b0;
    while (ang >= HALF) ang -= FULL;
    while (ang < -HALF) ang += FULL;
    if (ang > QUARTER) begin
      ang -= HALF;
      flip = 1'b1;
    end else if (ang < -QUARTER) begin
      ang += HALF;
      flip = 1'b1;
    end
    z = ang * (longint'(1) <<< ANG_FRAC_SHIFT);
    x = longint'(GAIN_Q30);
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ARCTAN_STEP[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ARCTAN_STEP[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cs = round_half_up(x, CX_FRAC - TRIG_FRAC);
    sn = round_half_up(y, CX_FRAC - TRIG_FRAC);
  endfunction

  // a*ca + b*cb, rounded, clipped; top bit flags the clip
  function automatic logic [COORD_W:0] blend_clip(input longint a, input longint ca,
                                                  input longint b, input longint cb);
    longint top;
    longint bottom;
    longint r;
    top    = (longint'(1) <<< (COORD_W - 1)) - 1;
    bottom = -top - 1;
    r      = round_half_up(a * ca + b * cb, TRIG_FRAC);
    if (r > top) return {1'b1, top[COORD_W-1:0]};
    if (r < bottom) return {1'b1, bottom[COORD_W-1:0]};
    return {1'b0, r[COORD_W-1:0]};
  endfunction

  function automatic rotated_t rotate_point(input point_t pt, input rpa_axis_e axis,
                                            input logic signed [ANG_W-1:0] angle);
    rotated_t res;
    longint   cs;
    longint   sn;
    longint   x;
    longint   y;
    longint   z;
    logic     s1;
    logic     s2;
    cordic_sin_cos(angle, cs, sn);
    x   = longint'(signed'(pt.coord_x));
    y   = longint'(signed'(pt.coord_y));
    z   = longint'(signed'(pt.coord_z));
    res = '{pt.coord_x, pt.coord_y, pt.coord_z, pt.last_point, 1'b0};
    s1  = 1'b0;
    s2  = 1'b0;
    // Both rotated coordinates come from the original point
    case (axis)
      AXIS_X: begin
        {s1, res.rot_y} = blend_clip(y, cs, z, -sn);
        {s2, res.rot_z} = blend_clip(z, cs, y, sn);
      end
      AXIS_Y: begin
        {s1, res.rot_x} = blend_clip(x, cs, z, sn);
        {s2, res.rot_z} = blend_clip(z, cs, x, -sn);
      end
      AXIS_Z: begin
        {s1, res.rot_x} = blend_clip(x, cs, y, -sn);
        {s2, res.rot_y} = blend_clip(y, cs, x, sn);
      end
      default: ;  // no axis: pass the point through untouched
    endcase
    res.saturated = s1 | s2;
    return res;
  endfunction

  // Full-range values half the time, with a share of extremes and small values
  function automatic coord_t rand_coord();
    case ($urandom_range(9))
      0:       return CMAX;
      1:       return CMIN;
      2, 3, 4: return coord_t'(int'($urandom_range(2097151)) - 1048576);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: track register writes, predict each accepted item, check results
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    point_t   seen;
    rotated_t got;
    rotated_t want;
    if (cfg_fire) begin
      cfg_writes++;
      case (cfg_bus.index)
        CFG_AXIS:  model_axis = rpa_axis_e'(cfg_bus.data[1:0]);
        CFG_ANGLE: model_angle = cfg_bus.data[ANG_W-1:0];
        default:   ;  // drop writes to unknown registers
      endcase
    end
    if (point_fire) begin
      points_sent++;
      seen = '{point_bus.coord_x, point_bus.coord_y, point_bus.coord_z,
               point_bus.last_point};
      if (point_known) pending_rotations.push_back(point_known_res);
      else pending_rotations.push_back(rotate_point(seen, model_axis, model_angle));
    end
    if (result_fire) begin
      got = '{result_bus.rot_x, result_bus.rot_y, result_bus.rot_z,
              result_bus.last_out, result_bus.saturated};
      if (got.saturated === 1'b1) sat_seen++;
      if (pending_rotations.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected rotated point x=%0d y=%0d z=%0d last=%b sat=%b",
                   $signed(got.rot_x), $signed(got.rot_y), $signed(got.rot_z),
                   got.last_out, got.saturated);
      end else begin
        want = pending_rotations.pop_front();
        if (got.rot_x !== want.rot_x || got.rot_y !== want.rot_y ||
            got.rot_z !== want.rot_z || got.last_out !== want.last_out ||
            got.saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("point %0d expected x=%0d y=%0d z=%0d last=%b sat=%b",
                     results_checked, $signed(want.rot_x), $signed(want.rot_y),
                     $signed(want.rot_z), want.last_out, want.saturated);
            $display("point %0d got      x=%0d y=%0d z=%0d last=%b sat=%b",
                     results_checked, $signed(got.rot_x), $signed(got.rot_y),
                     $signed(got.rot_z), got.last_out, got.saturated);
          end
        end
        results_checked++;
      end
    end
  end

  // End the run when no item moves on any channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || point_fire || result_fire || cfg_fire) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, plus one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned hold_left;
    logic        hold_done;
    result_bus.ready = 1'b0;
    hold_left        = 0;
    hold_done        = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        // hold off so the pipeline fills and stalls the input
        result_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        result_bus.ready <= !gaps_on || ($urandom_range(99) >= 6);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side; every task starts and ends on a falling edge
  // ---------------------------------------------------------------------------

  task automatic send_point(input point_t pt, input logic known, input rotated_t known_res);
    // idle now and then
    while (gaps_on && $urandom_range(99) < 6) begin
      point_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    point_bus.valid      <= 1'b1;
    point_bus.coord_x    <= pt.coord_x;
    point_bus.coord_y    <= pt.coord_y;
    point_bus.coord_z    <= pt.coord_z;
    point_bus.last_point <= pt.last_point;
    point_known          <= known;
    point_known_res      <= known_res;
    do @(posedge clk_i); while (!point_fire);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every rotated point has come back
  task automatic drain_points();
    point_bus.valid <= 1'b0;
    while (pending_rotations.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (!cfg_fire);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    dir_row_t                row;
    point_t                  pt;
    rpa_axis_e               drv_axis;
    rpa_axis_e               phase_axis;
    logic signed [ANG_W-1:0] drv_angle;
    logic signed [ANG_W-1:0] phase_angle;
    logic [CFG_DATA_W-1:0]   word;

    rst_ni               = 1'b0;
    point_bus.valid      = 1'b0;
    point_bus.coord_x    = '0;
    point_bus.coord_y    = '0;
    point_bus.coord_z    = '0;
    point_bus.last_point = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = CFG_AXIS;
    cfg_bus.data         = '0;
    point_known          = 1'b0;
    point_known_res      = '0;
    gaps_on              = 1'b1;
    hold_req             = 1'b0;
    model_axis           = AXIS_X;
    model_angle          = '0;
    drv_axis             = AXIS_X;
    drv_angle            = '0;
    points_sent          = 0;
    results_checked      = 0;
    sat_seen             = 0;
    cfg_writes           = 0;
    mismatches           = 0;
    quiet_cycles         = 0;

    // The first rows run on the reset setting (X axis, zero angle) with no
    // write at all. Angles are degrees times 256.
    dir_rows = '{
      // origin stays at the origin whatever the angle
      '{AXIS_X, 18'sd0, '{32'sd0, 32'sd0, 32'sd0, 1'b1},
        1'b1, '{32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0}},
      // axis coordinate passes, zero others stay zero
      '{AXIS_X, 18'sd0, '{32'sh0001_2345, 32'sd0, 32'sd0, 1'b0},
        1'b1, '{32'sh0001_2345, 32'sd0, 32'sd0, 1'b0, 1'b0}},
      '{AXIS_X, 18'sd0, '{CMIN, CMAX, CMIN, 1'b1}, 1'b0, '0},
      // 45 degrees on full-scale values: clip high, then clip low
      '{AXIS_X, 18'sd11520, '{32'sd0, CMAX, CMAX, 1'b0}, 1'b0, '0},
      '{AXIS_X, 18'sd11520, '{CMAX, CMIN, CMIN, 1'b1}, 1'b0, '0},
      // half turn, both signs, negating the most negative value
      '{AXIS_Y, 18'sd46080, '{CMIN, 32'sh1234_5678, 32'sd0, 1'b0}, 1'b0, '0},
      '{AXIS_Y, -18'sd46080, '{CMAX, CMIN, CMAX, 1'b1}, 1'b0, '0},
      // quarter turns
      '{AXIS_Z, 18'sd23040, '{32'sh0001_0000, 32'sd0, -32'sd5, 1'b0}, 1'b0, '0},
      '{AXIS_Z, -18'sd23040, '{32'sd0, 32'sh0001_0000, 32'sd7, 1'b1}, 1'b0, '0},
      // just past a quarter turn: folded by half a turn
      '{AXIS_Z, 18'sd23296, '{32'sh0001_0000, -32'sh0002_0000, 32'sd0, 1'b0},
        1'b0, '0},
      '{AXIS_Z, -18'sd23296, '{-32'sh0003_8000, 32'sh0000_4000, 32'sd1, 1'b1},
        1'b0, '0},
      // full turns, both signs
      '{AXIS_X, 18'sd92160, '{32'sd3, 32'sh0064_0000, -32'sh0032_0000, 1'b0},
        1'b0, '0},
      '{AXIS_X, -18'sd92160, '{-32'sd3, -32'sh0064_0000, 32'sh0032_0000, 1'b1},
        1'b0, '0},
      // register extremes, beyond a full turn
      '{AXIS_Y, 18'sh1ffff, '{CMAX, -32'sd1, CMIN, 1'b1}, 1'b0, '0},
      '{AXIS_Y, 18'sh20000, '{-32'sd1, CMAX, 32'sh00a0_0000, 1'b0}, 1'b0, '0},
      // no axis: point passes, never saturated
      '{AXIS_NONE, 18'sd7680, '{CMAX, CMIN, 32'sh5555_5555, 1'b1},
        1'b1, '{CMAX, CMIN, 32'sh5555_5555, 1'b1, 1'b0}},
      '{AXIS_NONE, 18'sd7680, '{CMIN, CMAX, 32'shaaaa_aaaa, 1'b0},
        1'b1, '{CMIN, CMAX, 32'shaaaa_aaaa, 1'b0, 1'b0}},
      // smallest step and the last step before a half turn
      '{AXIS_Z, 18'sd1, '{CMAX, CMAX, 32'sd0, 1'b1}, 1'b0, '0},
      '{AXIS_Z, 18'sd46079, '{-32'sd1, 32'sd1, CMIN, 1'b0}, 1'b0, '0},
      '{AXIS_X, -18'sd1, '{32'sd0, CMIN, CMIN, 1'b1}, 1'b0, '0}
    };

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows; drain before any setting changes
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = dir_rows[r];
      if (row.axis != drv_axis || row.angle != drv_angle) begin
        drain_points();
        if (row.axis != drv_axis) begin
          word      = '0;
          word[1:0] = row.axis;
          cfg_write(CFG_AXIS, word);
          drv_axis = row.axis;
        end
        if (row.angle != drv_angle) begin
          word            = '0;
          word[ANG_W-1:0] = row.angle;
          cfg_write(CFG_ANGLE, word);
          drv_angle = row.angle;
        end
      end
      send_point(row.pt, row.known, row.known_res);
    end
    drain_points();

    // Random phases: one setting each, junk in the unused data bits
    for (int p = 0; p < PHASES; p++) begin
      phase_axis = rpa_axis_e'(2'(p % 4));
      case (p)
        0:       phase_angle = 18'sh1ffff;
        1:       phase_angle = 18'sh20000;
        default: begin
          if ($urandom_range(3) == 0) phase_angle = ANG_W'($urandom);
          else phase_angle = ANG_W'(int'($urandom_range(2 * FULL)) - FULL);
        end
      endcase
      word      = $urandom;
      word[1:0] = phase_axis;
      cfg_write(CFG_AXIS, word);
      word            = $urandom;
      word[ANG_W-1:0] = phase_angle;
      cfg_write(CFG_ANGLE, word);
      // writes to unknown registers must leave the setting alone
      if (p % 3 == 2)
        cfg_write(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, CFG_ANGLE + 1)), $urandom);
      // two phases with no idling on either side
      gaps_on <= !(p == 5 || p == 6);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 3 && k == 5) hold_req <= 1'b1;
        pt = '{rand_coord(), rand_coord(), rand_coord(), 1'($urandom_range(1))};
        send_point(pt, 1'b0, '0);
      end
      drain_points();
    end

    // Let stray results show up
    repeat (2 * LATENCY) @(posedge clk_i);

    if (pending_rotations.size() != 0) begin
      $display("%0d rotated points never came out", pending_rotations.size());
      mismatches += pending_rotations.size();
    end
    $display("covered %0d points (%0d clipped) over %0d register writes,",
             points_sent, sat_seen, cfg_writes);
    $display("all axes, folded and wrapped angles, and a long output stall; %0d bad",
             mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/rpa_pkg.sv
rtl/core/rpa_point_if.sv
rtl/core/rpa_result_if.sv
rtl/core/rpa_cfg_if.sv
rtl/core/rpa_cordic_stage.sv
rtl/core/rpa_mix.sv
rtl/core/rotate_points_about_axis.sv
sim/rotate_points_about_axis_tb.sv
